### hw/rtl/bfra_pkg.sv
// Package for the best-fit range allocator: sizes, codes and shared types.
// Used by all modules of the block; depends on nothing.
`timescale 1ns / 1ps
package bfra_pkg;
	localparam int MAX_SLOTS = 1024;
	localparam int MAX_BLOCKS = 512;
	localparam int PENDING_DEPTH = 64;
	localparam int SW = 11;
	localparam int OW = 10;
	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int FW = 64;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BADCNT = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [OW-1:0] granted_slot;
		logic [SW-1:0] free_total;
		logic [SW-1:0] largest_free;
		logic [6:0] released_count;
	} result_t;
endpackage

### hw/rtl/bfra_table.sv
// Free block table of the allocator: start, size and valid per entry in one memory.
// One write and one registered read a cycle; depends on bfra_pkg.
// A clearing pass after reset and after each init leaves only entry zero valid.
`timescale 1ns / 1ps
module bfra_table (
	input logic clk,
	input logic arst_n,
	input logic init,
	input logic [bfra_pkg::SW-1:0] init_size,
	output logic busy,
	input logic [bfra_pkg::BW-1:0] rd_addr,
	output logic [bfra_pkg::OW-1:0] rd_start,
	output logic [bfra_pkg::SW-1:0] rd_size,
	output logic rd_valid,
	input logic wr_en,
	input logic [bfra_pkg::BW-1:0] wr_addr,
	input logic [bfra_pkg::OW-1:0] wr_start,
	input logic [bfra_pkg::SW-1:0] wr_size,
	input logic wr_valid
);
	localparam int DW = bfra_pkg::OW + bfra_pkg::SW + 1;
	logic [DW-1:0] mem [bfra_pkg::MAX_BLOCKS];
	logic [DW-1:0] rdat_q;
	logic [bfra_pkg::BW:0] clr_q;
	logic [bfra_pkg::SW-1:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			size_q <= bfra_pkg::SW'(bfra_pkg::MAX_SLOTS);
		end else if (init) begin
			clr_q <= '0;
			size_q <= init_size;
		end else if (!clr_q[bfra_pkg::BW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[bfra_pkg::BW])
			mem[clr_q[bfra_pkg::BW-1:0]] <= (clr_q == '0) ?
				{{bfra_pkg::OW{1'b0}}, size_q, 1'b1} : '0;
		else if (wr_en)
			mem[wr_addr] <= {wr_start, wr_size, wr_valid};
		rdat_q <= mem[rd_addr];
	end

	assign busy = !clr_q[bfra_pkg::BW];
	assign rd_start = rdat_q[DW-1:bfra_pkg::SW+1];
	assign rd_size = rdat_q[bfra_pkg::SW:1];
	assign rd_valid = rdat_q[0];
endmodule

### hw/rtl/bfra_pending.sv
// FIFO memory of pending frees: start, size and frame tag per entry.
// One write and one registered read a cycle; read entries only after written (the block does not enforce it).
`timescale 1ns / 1ps
module bfra_pending (
	input logic clk,
	input logic wr_en,
	input logic [bfra_pkg::PW-1:0] wr_addr,
	input logic [bfra_pkg::OW-1:0] wr_start,
	input logic [bfra_pkg::SW-1:0] wr_size,
	input logic [bfra_pkg::FW-1:0] wr_frame,
	input logic [bfra_pkg::PW-1:0] rd_addr,
	output logic [bfra_pkg::OW-1:0] rd_start,
	output logic [bfra_pkg::SW-1:0] rd_size,
	output logic [bfra_pkg::FW-1:0] rd_frame
);
	localparam int DW = bfra_pkg::OW + bfra_pkg::SW + bfra_pkg::FW;
	logic [DW-1:0] mem [bfra_pkg::PENDING_DEPTH];
	logic [DW-1:0] rdat_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_start, wr_size, wr_frame};
		rdat_q <= mem[rd_addr];
	end

	assign rd_start = rdat_q[DW-1:bfra_pkg::SW+bfra_pkg::FW];
	assign rd_size = rdat_q[bfra_pkg::SW+bfra_pkg::FW-1:bfra_pkg::FW];
	assign rd_frame = rdat_q[bfra_pkg::FW-1:0];
endmodule

### hw/rtl/best_fit_range_allocator.sv
// Top level of the best-fit range allocator: sequencer that scans the block table.
// Depends on bfra_pkg, bfra_table and bfra_pending.
//
// Channel   Dir  Fields
// cfg       in   heap_slots (cfg_data, 11 bits)
// s_axis    in   tdata: opcode, count, start_slot, frame
// m_axis    out  tdata: status, granted_slot, free_total, largest_free, released_count
//
// A table scan reads one entry a cycle. From acceptance to result, a free, an unused
// opcode or a rejected allocate takes one scan for the largest block; an allocate that
// searches takes a search scan, an update and a rescan for the largest block.
// A release takes a merge scan and update per drained entry, plus a write per two-sided
// merge, then a rescan. After reset and each config write a clearing pass holds both channels off.
// The result register holds one transaction; a new item waits until it is taken.
`timescale 1ns / 1ps
module best_fit_range_allocator (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [10:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[1:0], count[12:2], start_slot[22:13], frame[86:23]
	input logic [87:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[1:0], granted_slot[11:2], free_total[22:12], largest_free[33:23],
	// released_count[40:34]
	output logic [47:0] m_axis_tdata
);
	localparam int SW = bfra_pkg::SW;
	localparam int OW = bfra_pkg::OW;
	localparam int BW = bfra_pkg::BW;
	localparam int PW = bfra_pkg::PW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_PEND = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_LSCAN = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [2:0] S_APPLY = 3'd6;
	localparam logic [2:0] S_PREAD = 3'd7;

	// Scan kinds.
	localparam logic [1:0] K_ALLOC = 2'd0;
	localparam logic [1:0] K_MERGE = 2'd1;
	localparam logic [1:0] K_LARGE = 2'd2;

	logic [2:0] state_q;
	logic [1:0] kind_q;
	logic [SW-1:0] heap_q, free_q;
	logic [SW-1:0] cnt_q;
	logic [63:0] frm_q;
	logic [PW-1:0] head_q;
	logic [PW:0] fill_q;
	logic [6:0] rel_q;
	logic [1:0] status_q;
	logic [OW-1:0] grant_q;
	logic [BW:0] idx_q;
	logic pipe_q;
	logic [BW-1:0] pidx_q;
	logic [SW-1:0] largest_q;
	// Best-fit search registers.
	logic best_ok_q;
	logic [BW-1:0] best_q;
	logic [OW-1:0] best_st_q;
	logic [SW-1:0] best_sz_q;
	// Merge search registers.
	logic [SW-1:0] ms_q, mc_q;
	logic ovl_q, prev_ok_q, next_ok_q, spare_ok_q;
	logic [BW-1:0] prev_q, next_q, spare_q;
	logic [OW-1:0] prev_st_q, next_st_q;
	logic [SW-1:0] prev_sz_q, next_sz_q;
	logic res_v_q;
	bfra_pkg::result_t res_q;

	logic [BW-1:0] rd_addr;
	logic [OW-1:0] t_st;
	logic [SW-1:0] t_sz;
	logic t_v;
	logic wr_en;
	logic [BW-1:0] wr_addr;
	logic [OW-1:0] wr_st;
	logic [SW-1:0] wr_sz;
	logic wr_v;
	logic init;
	logic tbl_busy;
	logic [SW-1:0] init_size, cfg_clamped;
	logic p_wr;
	logic [PW-1:0] p_waddr;
	logic [OW-1:0] p_st;
	logic [SW-1:0] p_sz;
	logic [63:0] p_fr;
	logic s_acc;
	logic [SW:0] t_end, m_end;

	assign cfg_ready = (state_q == S_IDLE) && !res_v_q && !tbl_busy;
	assign s_axis_tready = (state_q == S_IDLE) && !res_v_q && !cfg_valid && !tbl_busy;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = res_v_q;
	assign m_axis_tdata = {7'd0, res_q.released_count, res_q.largest_free, res_q.free_total,
		res_q.granted_slot, res_q.status};

	always_comb begin
		cfg_clamped = cfg_data;
		if (cfg_data == '0)
			cfg_clamped = SW'(1);
		else if (cfg_data > SW'(bfra_pkg::MAX_SLOTS))
			cfg_clamped = SW'(bfra_pkg::MAX_SLOTS);
	end
	assign init = !arst_n ? 1'b0 : (cfg_valid && cfg_ready);
	assign init_size = cfg_clamped;
	assign rd_addr = idx_q[BW-1:0];

	bfra_table u_table (
		.clk(clk), .arst_n(arst_n), .init(init), .init_size(init_size), .busy(tbl_busy),
		.rd_addr(rd_addr), .rd_start(t_st), .rd_size(t_sz), .rd_valid(t_v),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_start(wr_st), .wr_size(wr_sz),
		.wr_valid(wr_v)
	);

	assign p_wr = s_acc && s_axis_tdata[1:0] == bfra_pkg::OP_FREE
		&& s_axis_tdata[12:2] != '0
		&& ({1'b0, 1'b0, s_axis_tdata[22:13]} + {1'b0, s_axis_tdata[12:2]}) <= {1'b0, heap_q}
		&& fill_q < (PW+1)'(bfra_pkg::PENDING_DEPTH);
	assign p_waddr = head_q + fill_q[PW-1:0];

	bfra_pending u_pend (
		.clk(clk), .wr_en(p_wr), .wr_addr(p_waddr),
		.wr_start(s_axis_tdata[22:13]), .wr_size(s_axis_tdata[12:2]),
		.wr_frame(s_axis_tdata[86:23]),
		.rd_addr(head_q), .rd_start(p_st), .rd_size(p_sz), .rd_frame(p_fr)
	);

	assign t_end = {1'b0, t_sz} + {1'b0, t_st};
	assign m_end = {1'b0, ms_q} + {1'b0, mc_q};

	// Table update decided at the end of a scan.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_st = '0;
		wr_sz = '0;
		wr_v = 1'b0;
		if (state_q == S_APPLY) begin
			if (kind_q == K_ALLOC) begin
				wr_en = best_ok_q;
				wr_addr = best_q;
				wr_st = best_st_q + OW'(cnt_q);
				wr_sz = best_sz_q - cnt_q;
				wr_v = best_sz_q != cnt_q;
			end else if (!ovl_q) begin
				if (prev_ok_q) begin
					wr_en = 1'b1;
					wr_addr = prev_q;
					wr_st = prev_st_q;
					wr_sz = prev_sz_q + mc_q + (next_ok_q ? next_sz_q : '0);
					wr_v = 1'b1;
				end else if (next_ok_q) begin
					wr_en = 1'b1;
					wr_addr = next_q;
					wr_st = ms_q[OW-1:0];
					wr_sz = next_sz_q + mc_q;
					wr_v = 1'b1;
				end else if (spare_ok_q) begin
					wr_en = 1'b1;
					wr_addr = spare_q;
					wr_st = ms_q[OW-1:0];
					wr_sz = mc_q;
					wr_v = 1'b1;
				end
			end
		end else if (state_q == S_CHECK) begin
			// Second write for a two-sided merge: the next block is now part of prev.
			wr_en = 1'b1;
			wr_addr = next_q;
			wr_st = next_st_q;
			wr_sz = next_sz_q;
			wr_v = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= K_ALLOC;
			heap_q <= SW'(bfra_pkg::MAX_SLOTS);
			free_q <= SW'(bfra_pkg::MAX_SLOTS);
			head_q <= '0;
			fill_q <= '0;
			res_v_q <= 1'b0;
			idx_q <= '0;
			pipe_q <= 1'b0;
		end else begin
			if (res_v_q && m_axis_tready)
				res_v_q <= 1'b0;
			if (init) begin
				heap_q <= cfg_clamped;
				free_q <= cfg_clamped;
				head_q <= '0;
				fill_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						idx_q <= '0;
						pipe_q <= 1'b0;
						if (s_axis_tdata[1:0] == bfra_pkg::OP_ALLOC
							&& s_axis_tdata[12:2] != '0
							&& s_axis_tdata[12:2] <= free_q) begin
							kind_q <= K_ALLOC;
							state_q <= S_SCAN;
						end else if (s_axis_tdata[1:0] == bfra_pkg::OP_RELEASE) begin
							state_q <= S_PREAD;
						end else begin
							if (p_wr)
								fill_q <= fill_q + 1'b1;
							kind_q <= K_LARGE;
							state_q <= S_SCAN;
						end
					end
				end
				S_PREAD: state_q <= S_PEND;
				S_PEND: begin
					if (fill_q != '0 && p_fr <= frm_q) begin
						idx_q <= '0;
						pipe_q <= 1'b0;
						kind_q <= K_MERGE;
						state_q <= S_SCAN;
					end else begin
						idx_q <= '0;
						pipe_q <= 1'b0;
						kind_q <= K_LARGE;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pipe_q <= !idx_q[BW];
					if (!idx_q[BW])
						idx_q <= idx_q + 1'b1;
					if (idx_q[BW] && pipe_q) begin
						pipe_q <= 1'b0;
					end else if (idx_q[BW] && !pipe_q) begin
						if (kind_q == K_LARGE)
							state_q <= S_DONE;
						else
							state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					idx_q <= '0;
					pipe_q <= 1'b0;
					if (kind_q == K_ALLOC) begin
						if (best_ok_q)
							free_q <= free_q - cnt_q;
						kind_q <= K_LARGE;
						state_q <= S_SCAN;
					end else if (!ovl_q && !prev_ok_q && !next_ok_q && !spare_ok_q) begin
						kind_q <= K_LARGE;
						state_q <= S_SCAN;
					end else begin
						if (!ovl_q)
							free_q <= free_q + mc_q;
						head_q <= head_q + 1'b1;
						fill_q <= fill_q - 1'b1;
						state_q <= (!ovl_q && prev_ok_q && next_ok_q) ? S_CHECK : S_PREAD;
					end
				end
				S_CHECK: state_q <= S_PREAD;
				S_DONE: begin
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: the shared compare unit walks one table entry per cycle.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cnt_q <= s_axis_tdata[12:2];
			frm_q <= s_axis_tdata[86:23];
			rel_q <= '0;
			grant_q <= '0;
			if (s_axis_tdata[1:0] == bfra_pkg::OP_ALLOC) begin
				if (s_axis_tdata[12:2] == '0)
					status_q <= bfra_pkg::ST_BADCNT;
				else if (s_axis_tdata[12:2] > free_q)
					status_q <= bfra_pkg::ST_NOFIT;
				else
					status_q <= bfra_pkg::ST_OK;
			end else if (s_axis_tdata[1:0] == bfra_pkg::OP_FREE) begin
				if (s_axis_tdata[12:2] == '0 || ({1'b0, 1'b0, s_axis_tdata[22:13]}
					+ {1'b0, s_axis_tdata[12:2]}) > {1'b0, heap_q})
					status_q <= bfra_pkg::ST_BADCNT;
				else if (fill_q >= (PW+1)'(bfra_pkg::PENDING_DEPTH))
					status_q <= bfra_pkg::ST_FULL;
				else
					status_q <= bfra_pkg::ST_OK;
			end else begin
				status_q <= bfra_pkg::ST_OK;
			end
		end
		if (state_q == S_PEND) begin
			ms_q <= {1'b0, p_st};
			mc_q <= p_sz;
		end
		if ((state_q == S_SCAN && idx_q == '0 && !pipe_q)) begin
			best_ok_q <= 1'b0;
			ovl_q <= (mc_q == '0) || (m_end > {1'b0, heap_q});
			prev_ok_q <= 1'b0;
			next_ok_q <= 1'b0;
			spare_ok_q <= 1'b0;
			largest_q <= '0;
		end else if (state_q == S_SCAN && pipe_q) begin
			if (t_v && t_sz > largest_q)
				largest_q <= t_sz;
			if (kind_q == K_ALLOC && t_v && t_sz >= cnt_q) begin
				if (!best_ok_q || t_sz < best_sz_q || (t_sz == best_sz_q && t_st < best_st_q)) begin
					best_ok_q <= 1'b1;
					best_q <= pidx_q;
					best_st_q <= t_st;
					best_sz_q <= t_sz;
				end
			end
			if (kind_q == K_MERGE) begin
				if (!t_v) begin
					if (!spare_ok_q) begin
						spare_ok_q <= 1'b1;
						spare_q <= pidx_q;
					end
				end else begin
					if ({1'b0, 1'b0, t_st} < m_end && {1'b0, ms_q} < t_end)
						ovl_q <= 1'b1;
					if ({1'b0, t_st} < ms_q) begin
						if (!prev_ok_q || t_st > prev_st_q) begin
							prev_ok_q <= 1'b1;
							prev_q <= pidx_q;
							prev_st_q <= t_st;
							prev_sz_q <= t_sz;
						end
					end else if (!next_ok_q || t_st < next_st_q) begin
						next_ok_q <= 1'b1;
						next_q <= pidx_q;
						next_st_q <= t_st;
						next_sz_q <= t_sz;
					end
				end
			end
		end
		pidx_q <= idx_q[BW-1:0];
		if (state_q == S_SCAN && idx_q[BW] && !pipe_q && kind_q == K_MERGE) begin
			if (prev_ok_q && ({1'b0, prev_st_q} + {1'b0, prev_sz_q}) != {1'b0, ms_q})
				prev_ok_q <= 1'b0;
			if (next_ok_q && m_end != {1'b0, 1'b0, next_st_q})
				next_ok_q <= 1'b0;
		end
		if (state_q == S_APPLY && kind_q == K_ALLOC) begin
			if (best_ok_q)
				grant_q <= best_st_q;
			else
				status_q <= bfra_pkg::ST_NOFIT;
		end
		if (state_q == S_APPLY && kind_q == K_MERGE && !ovl_q
			&& (prev_ok_q || next_ok_q || spare_ok_q))
			rel_q <= rel_q + 1'b1;
		if (state_q == S_DONE) begin
			res_q.status <= status_q;
			res_q.granted_slot <= grant_q;
			res_q.free_total <= free_q;
			res_q.largest_free <= largest_q;
			res_q.released_count <= rel_q;
		end
	end

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) s_axis_tready |-> state_q == S_IDLE;
	endproperty
	assert property (p_ready_idle) else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (PW+1)'(bfra_pkg::PENDING_DEPTH)) else $error("fifo overfill");
	assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= heap_q) else $error("free above heap");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> m_axis_tvalid) else $error("result lost");
endmodule
